// ===== sv/mphd_pkg.sv =====
// Shared types and constants for the pairwise Hamming distance block.
// Used by mphd_ctrl, mphd_dp and msa_pairwise_hamming_distance.
`default_nettype none

package mphd_pkg;

    localparam int MAX_ROWS_DEF    = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int RESIDUE_W   = 8;
    localparam int ROW_FIELD_W = 3;
    localparam int DIST_W      = 16;
    localparam int ROWCNT_W    = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_GAPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_CODE     = 2'd2;

    localparam logic [ROWCNT_W-1:0]  ROW_COUNT_RST = 4'd8;
    localparam logic                 EXCLUDE_RST   = 1'b0;
    localparam logic [RESIDUE_W-1:0] GAP_CODE_RST  = 8'd45;

    typedef enum logic [0:0] {
        ST_RUN  = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        logic take;
        logic emit_start;
        logic advance;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last_pair;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/mphd_ctrl.sv =====
// Controller: accepts residues, then walks the result table on end of alignment.
// Depends on mphd_pkg for state and command types.
`default_nettype none

module mphd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_end_of_alignment,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire mphd_pkg::stat_t stat,
    output mphd_pkg::cmd_t     cmd
);

    mphd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mphd_pkg::ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mphd_pkg::ST_RUN: begin
                if (s_valid && s_end_of_alignment) begin
                    state_next = mphd_pkg::ST_EMIT;
                end
            end
            mphd_pkg::ST_EMIT: begin
                if (m_ready && stat.last_pair) begin
                    state_next = mphd_pkg::ST_RUN;
                end
            end
            default: state_next = mphd_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        cmd            = '0;
        case (state_reg)
            mphd_pkg::ST_RUN: begin
                s_ready        = 1'b1;
                cmd.take       = s_valid;
                cmd.emit_start = s_valid && s_end_of_alignment;
            end
            mphd_pkg::ST_EMIT: begin
                m_valid     = 1'b1;
                cmd.advance = m_ready;
                cmd.finish  = m_ready && stat.last_pair;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/mphd_dp.sv =====
// Datapath: configuration registers, column residues, pair counters and result select.
// Depends on mphd_pkg; driven by commands from mphd_ctrl.
`default_nettype none

module mphd_dp #(
    parameter int MAX_ROWS    = mphd_pkg::MAX_ROWS_DEF,
    parameter int COUNT_WIDTH = mphd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    input  wire logic [mphd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mphd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [mphd_pkg::RESIDUE_W-1:0]      s_residue,
    input  wire logic                                s_end_of_alignment,
    input  wire mphd_pkg::cmd_t                      cmd,
    output mphd_pkg::stat_t                          stat,
    output logic [mphd_pkg::ROW_FIELD_W-1:0]         m_row_a,
    output logic [mphd_pkg::ROW_FIELD_W-1:0]         m_row_b,
    output logic [mphd_pkg::DIST_W-1:0]              m_distance,
    output logic                                     m_last_result
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [RCW-1:0] ROWS_MAX = RCW'(MAX_ROWS);

    logic [mphd_pkg::ROWCNT_W-1:0]  row_count_reg;
    logic                           exclude_reg;
    logic [mphd_pkg::RESIDUE_W-1:0] gap_code_reg;

    logic [RW-1:0] pos_reg, pos_next;
    logic [RW-1:0] ea_reg, ea_next;
    logic [RW-1:0] eb_reg, eb_next;

    logic [mphd_pkg::RESIDUE_W-1:0] col_reg [MAX_ROWS];
    logic [COUNT_WIDTH-1:0]         cnt_reg [MAX_ROWS][MAX_ROWS];

    logic [RCW-1:0] rows;
    logic [RW-1:0]  r_cur;
    logic [RW-1:0]  r_inc;
    logic [RW-1:0]  last_row;
    logic [MAX_ROWS-1:0] diff;
    logic [COUNT_WIDTH-1:0] cnt_sel;
    logic [32:0] cnt_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= mphd_pkg::ROW_COUNT_RST;
            exclude_reg   <= mphd_pkg::EXCLUDE_RST;
            gap_code_reg  <= mphd_pkg::GAP_CODE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                mphd_pkg::REG_ROW_COUNT:    row_count_reg <= cfg_data[mphd_pkg::ROWCNT_W-1:0];
                mphd_pkg::REG_EXCLUDE_GAPS: exclude_reg   <= cfg_data[0];
                mphd_pkg::REG_GAP_CODE:     gap_code_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (row_count_reg == '0) begin
            rows = RCW'(1);
        end else if (32'(row_count_reg) > 32'(MAX_ROWS)) begin
            rows = ROWS_MAX;
        end else begin
            rows = RCW'(row_count_reg);
        end
        last_row = RW'(rows - RCW'(1));
        r_cur    = (RCW'(pos_reg) >= rows) ? '0 : pos_reg;
        r_inc    = (r_cur == last_row) ? '0 : RW'(r_cur + RW'(1));
    end

    always_comb begin
        for (int a = 0; a < MAX_ROWS; a++) begin
            diff[a] = (RW'(a) < r_cur) && (col_reg[a] != s_residue) &&
                      !(exclude_reg && ((col_reg[a] == gap_code_reg) ||
                                        (s_residue == gap_code_reg)));
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (cmd.take) begin
            pos_next = s_end_of_alignment ? '0 : r_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            col_reg[r_cur] <= s_residue;
        end
    end

    for (genvar ga = 0; ga < MAX_ROWS; ga++) begin : g_row
        for (genvar gb = 0; gb < MAX_ROWS; gb++) begin : g_col
            if (gb > ga) begin : g_pair
                always_ff @(posedge aclk) begin
                    if (!aresetn || cmd.finish) begin
                        cnt_reg[ga][gb] <= '0;
                    end else if (cmd.take && diff[ga] && (r_cur == RW'(gb)) &&
                                 (cnt_reg[ga][gb] != CNT_MAX)) begin
                        cnt_reg[ga][gb] <= cnt_reg[ga][gb] + COUNT_WIDTH'(1);
                    end
                end
            end else begin : g_none
                always_ff @(posedge aclk) begin
                    cnt_reg[ga][gb] <= '0;
                end
            end
        end
    end

    always_comb begin
        ea_next = ea_reg;
        eb_next = eb_reg;
        if (cmd.emit_start) begin
            ea_next = '0;
            eb_next = '0;
        end else if (cmd.advance) begin
            if (eb_reg == last_row) begin
                ea_next = RW'(ea_reg + RW'(1));
                eb_next = RW'(ea_reg + RW'(1));
            end else begin
                eb_next = RW'(eb_reg + RW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ea_reg <= '0;
            eb_reg <= '0;
        end else begin
            ea_reg <= ea_next;
            eb_reg <= eb_next;
        end
    end

    always_comb begin
        cnt_sel   = (ea_reg == eb_reg) ? '0 : cnt_reg[ea_reg][eb_reg];
        cnt_wide  = 33'(cnt_sel);
        m_distance = (cnt_wide > 33'h0FFFF) ? {mphd_pkg::DIST_W{1'b1}}
                                            : cnt_wide[mphd_pkg::DIST_W-1:0];
        m_row_a   = mphd_pkg::ROW_FIELD_W'(ea_reg);
        m_row_b   = mphd_pkg::ROW_FIELD_W'(eb_reg);
        stat.last_pair = (ea_reg == last_row) && (eb_reg == last_row);
        m_last_result  = stat.last_pair;
    end

endmodule

`default_nettype wire

// ===== sv/msa_pairwise_hamming_distance.sv =====
// Pairwise Hamming distance over the rows of an alignment, fed one residue per
// item in column-major order. Residues are taken one per cycle; each is compared
// against the residues already held for its column, and the counter of every
// differing pair is bumped in the same cycle. The item flagged end_of_alignment
// is counted like any other, then the block stops taking items and emits
// R*(R+1)/2 result items (R = effective row count), one per cycle while m_ready
// is high, walked by the row indices ea_reg/eb_reg in the datapath; the counters
// clear with the last result. Configuration writes are always ready.
// Depends on mphd_pkg, mphd_ctrl and mphd_dp.
`default_nettype none

module msa_pairwise_hamming_distance #(
    parameter int MAX_ROWS    = mphd_pkg::MAX_ROWS_DEF,
    parameter int COUNT_WIDTH = mphd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mphd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mphd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [mphd_pkg::RESIDUE_W-1:0]    s_residue,
    input  wire logic                              s_end_of_alignment,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [mphd_pkg::ROW_FIELD_W-1:0]       m_row_a,
    output logic [mphd_pkg::ROW_FIELD_W-1:0]       m_row_b,
    output logic [mphd_pkg::DIST_W-1:0]            m_distance,
    output logic                                   m_last_result
);

    mphd_pkg::cmd_t  cmd;
    mphd_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    mphd_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_end_of_alignment (s_end_of_alignment),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .stat               (stat),
        .cmd                (cmd)
    );

    mphd_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_residue          (s_residue),
        .s_end_of_alignment (s_end_of_alignment),
        .cmd                (cmd),
        .stat               (stat),
        .m_row_a            (m_row_a),
        .m_row_b            (m_row_b),
        .m_distance         (m_distance),
        .m_last_result      (m_last_result)
    );

endmodule

`default_nettype wire
